>>> hdl/substring_equality_double_hash_assert.svh
// Assertion macros for the substring equality hash block.
// Included by the RTL modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SUBSTRING_EQUALITY_DOUBLE_HASH_ASSERT_SVH
`define SUBSTRING_EQUALITY_DOUBLE_HASH_ASSERT_SVH
`ifndef SYNTHESIS
`define SEDH_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sedh: assertion failed");
`define SEDH_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("sedh: assertion failed");
`else
`define SEDH_ASSERT(label, prop)
`define SEDH_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hdl/sedh_pkg.sv
// Shared types, constants and the modular reduction function of the substring hash block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sedh_pkg;

  localparam int MAX_TEXT = 1024;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int CH_W     = 8;
  localparam int START_W  = 10;
  localparam int SPAN_W   = 11;
  localparam int HASH_W   = 31;
  localparam int BIT_W    = $clog2(HASH_W);
  localparam int RANGE_W  = 12;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 128;
  localparam int LANES      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_TWO = 2'd2;

  localparam logic [HASH_W-1:0] HASH_BASE_RST   = 31'd263;
  localparam logic [HASH_W-1:0] MODULUS_ONE_RST = 31'd1000000007;
  localparam logic [HASH_W-1:0] MODULUS_TWO_RST = 31'd1000000009;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 2'd0,
    OP_COMPARE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_HOLD = 3'd0,
    PH_INIT = 3'd1,
    PH_CRED = 3'd2,
    PH_MUL  = 3'd3,
    PH_ADD  = 3'd4
  } lane_phase_e;

  typedef struct packed {
    lane_phase_e phase;
    logic        last;
  } lane_cmd_t;

  typedef struct packed {
    logic        accept;
    logic        read;
    lane_phase_e phase;
    logic        emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_cmp;
    logic crd_last;
    logic mul_last;
    logic k_one;
    logic out_free;
  } ctrl_stat_t;

  // Reduces a value below three times the modulus into the range of the modulus.
  function automatic logic [HASH_W-1:0] mod_reduce(input logic [HASH_W+1:0] t,
                                                   input logic [HASH_W-1:0] m);
    logic [HASH_W+2:0] tt;
    logic [HASH_W+2:0] m1;
    logic [HASH_W+2:0] m2;
    logic [HASH_W+2:0] d;
    tt = {1'b0, t};
    m1 = {3'b000, m};
    m2 = {2'b00, m, 1'b0};
    if (tt >= m2) begin
      d = tt - m2;
    end else if (tt >= m1) begin
      d = tt - m1;
    end else begin
      d = tt;
    end
    return d[HASH_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/sedh_lane.sv
// One hash lane: bit-serial modular multiply-add applying Horner's rule one character at a time.
// Depends on sedh_pkg and the assertion macro header.
`default_nettype none
`include "substring_equality_double_hash_assert.svh"
module sedh_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sedh_pkg::lane_cmd_t           cmd_i,
  input  wire logic                          ch_bit_i,
  input  wire logic                          base_bit_i,
  input  wire logic [sedh_pkg::HASH_W-1:0]   modulus_i,
  output logic      [sedh_pkg::HASH_W-1:0]   hash_o
);

  logic [sedh_pkg::HASH_W-1:0] acc_q, acc_d;
  logic [sedh_pkg::HASH_W-1:0] cm_q, cm_d;
  logic [sedh_pkg::HASH_W-1:0] h_q, h_d;
  logic [sedh_pkg::HASH_W+1:0] sum;
  logic [sedh_pkg::HASH_W-1:0] res;

  always_comb begin
    case (cmd_i.phase)
      sedh_pkg::PH_CRED: begin
        sum = {1'b0, acc_q, 1'b0} + {{(sedh_pkg::HASH_W+1){1'b0}}, ch_bit_i};
      end
      sedh_pkg::PH_MUL: begin
        sum = {1'b0, acc_q, 1'b0} + (base_bit_i ? {2'b00, h_q} : '0);
      end
      sedh_pkg::PH_ADD: begin
        sum = {2'b00, acc_q} + {2'b00, cm_q};
      end
      default: begin
        sum = '0;
      end
    endcase
    res = sedh_pkg::mod_reduce(sum, modulus_i);
  end

  always_comb begin
    acc_d = acc_q;
    cm_d  = cm_q;
    h_d   = h_q;
    case (cmd_i.phase)
      sedh_pkg::PH_INIT: begin
        acc_d = '0;
        h_d   = '0;
      end
      sedh_pkg::PH_CRED: begin
        if (cmd_i.last) begin
          cm_d  = res;
          acc_d = '0;
        end else begin
          acc_d = res;
        end
      end
      sedh_pkg::PH_MUL: begin
        acc_d = res;
      end
      sedh_pkg::PH_ADD: begin
        h_d   = res;
        acc_d = '0;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cm_q  <= cm_d;
    h_q   <= h_d;
  end

  // A zero modulus yields a zero hash by definition.
  assign hash_o = (modulus_i == '0) ? '0 : h_q;

  `SEDH_ASSERT(a_lane_init_clears, (cmd_i.phase == sedh_pkg::PH_INIT) |=> (h_q == '0 && acc_q == '0))

endmodule
`default_nettype wire

>>> hdl/sedh_ctrl.sv
// Control FSM sequencing accept, read, character reduction, multiply, add and emit.
// Depends on sedh_pkg and the assertion macro header.
`default_nettype none
`include "substring_equality_double_hash_assert.svh"
module sedh_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire sedh_pkg::ctrl_stat_t stat_i,
  output sedh_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_CRED = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.read   = 1'b0;
    cmd_o.phase  = sedh_pkg::PH_HOLD;
    cmd_o.emit   = 1'b0;
    s_ready_o    = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.phase  = sedh_pkg::PH_INIT;
          state_d      = stat_i.go_cmp ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CRED;
      end
      ST_CRED: begin
        cmd_o.phase = sedh_pkg::PH_CRED;
        if (stat_i.crd_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.phase = sedh_pkg::PH_MUL;
        if (stat_i.mul_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.phase = sedh_pkg::PH_ADD;
        state_d     = stat_i.k_one ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SEDH_ASSERT(a_ctrl_mul_after_last_bit, (state_q == ST_MUL && $past(state_q == ST_CRED)) |-> $past(stat_i.crd_last))

endmodule
`default_nettype wire

>>> hdl/sedh_datapath.sv
// Datapath: text store, request and configuration registers, four hash lanes and result register.
// Depends on sedh_pkg, sedh_lane and the assertion macro header.
`default_nettype none
`include "substring_equality_double_hash_assert.svh"
module sedh_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sedh_pkg::ctrl_cmd_t                 cmd_i,
  output sedh_pkg::ctrl_stat_t                     stat_o,
  input  wire sedh_pkg::op_e                       op_i,
  input  wire logic [sedh_pkg::CH_W-1:0]           ch_i,
  input  wire logic [sedh_pkg::START_W-1:0]        first_start_i,
  input  wire logic [sedh_pkg::START_W-1:0]        second_start_i,
  input  wire logic [sedh_pkg::SPAN_W-1:0]         span_length_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [sedh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [sedh_pkg::HASH_W-1:0]         cfg_data_i,
  output logic                                     m_valid_o,
  input  wire logic                                m_ready_i,
  output logic [sedh_pkg::OUT_DATA_W-1:0]          m_data_o,
  output logic [sedh_pkg::STAT_W-1:0]              m_user_o
);

  logic [sedh_pkg::CH_W-1:0] mem [sedh_pkg::MAX_TEXT];

  logic [sedh_pkg::HASH_W-1:0]  base_q, mod_one_q, mod_two_q;
  logic [sedh_pkg::LEN_W-1:0]   length_q, length_d;
  logic [sedh_pkg::START_W-1:0] a_q, b_q;
  logic [sedh_pkg::SPAN_W-1:0]  k_q;
  logic [sedh_pkg::BIT_W-1:0]   bitcnt_q;
  logic [sedh_pkg::CH_W-1:0]    rd_a_q, rd_b_q;
  sedh_pkg::status_e            status_q, status_d;
  logic                         cmp_ok_q;
  logic                         out_valid_q;
  sedh_pkg::status_e            out_status_q;
  logic                         out_equal_q;
  logic [sedh_pkg::HASH_W-1:0]  out_hash_q [sedh_pkg::LANES];

  logic [sedh_pkg::RANGE_W-1:0] end_a, end_b, addr_a, addr_b;
  logic                         full, range_bad, do_write;
  logic                         crd_last, mul_last;
  logic                         ch_bit_a, ch_bit_b, base_bit;
  logic [2:0]                   ch_idx;
  logic [sedh_pkg::BIT_W-1:0]   base_idx;
  sedh_pkg::lane_cmd_t          lane_cmd;
  logic [sedh_pkg::HASH_W-1:0]  hash [sedh_pkg::LANES];
  logic                         equal;

  assign end_a = sedh_pkg::RANGE_W'(first_start_i) + sedh_pkg::RANGE_W'(span_length_i);
  assign end_b = sedh_pkg::RANGE_W'(second_start_i) + sedh_pkg::RANGE_W'(span_length_i);
  assign range_bad = (end_a > sedh_pkg::RANGE_W'(length_q))
                  || (end_b > sedh_pkg::RANGE_W'(length_q));
  assign full = (length_q >= sedh_pkg::LEN_W'(sedh_pkg::MAX_TEXT));
  assign do_write = cmd_i.accept && (op_i == sedh_pkg::OP_APPEND) && !full;

  always_comb begin
    length_d = length_q;
    status_d = sedh_pkg::STATUS_OK;
    case (op_i)
      sedh_pkg::OP_APPEND: begin
        if (full) begin
          status_d = sedh_pkg::STATUS_FULL;
        end else begin
          length_d = length_q + sedh_pkg::LEN_W'(1);
        end
      end
      sedh_pkg::OP_COMPARE: begin
        if (range_bad) begin
          status_d = sedh_pkg::STATUS_RANGE;
        end
      end
      sedh_pkg::OP_CLEAR: begin
        length_d = '0;
      end
      default: begin
        status_d = sedh_pkg::STATUS_OK;
      end
    endcase
  end

  // Positions are walked from the last character of each span back to the first.
  assign addr_a = sedh_pkg::RANGE_W'(a_q) + sedh_pkg::RANGE_W'(k_q) - sedh_pkg::RANGE_W'(1);
  assign addr_b = sedh_pkg::RANGE_W'(b_q) + sedh_pkg::RANGE_W'(k_q) - sedh_pkg::RANGE_W'(1);

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[length_q[sedh_pkg::ADDR_W-1:0]] <= ch_i;
    end
    if (cmd_i.read) begin
      rd_a_q <= mem[addr_a[sedh_pkg::ADDR_W-1:0]];
      rd_b_q <= mem[addr_b[sedh_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= sedh_pkg::HASH_BASE_RST;
      mod_one_q <= sedh_pkg::MODULUS_ONE_RST;
      mod_two_q <= sedh_pkg::MODULUS_TWO_RST;
      length_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sedh_pkg::CFG_HASH_BASE:   base_q    <= cfg_data_i;
          sedh_pkg::CFG_MODULUS_ONE: mod_one_q <= cfg_data_i;
          sedh_pkg::CFG_MODULUS_TWO: mod_two_q <= cfg_data_i;
          default: begin
            base_q <= base_q;
          end
        endcase
      end
      if (cmd_i.accept) begin
        length_q <= length_d;
      end
    end
  end

  assign crd_last = (bitcnt_q == sedh_pkg::BIT_W'(sedh_pkg::CH_W - 1));
  assign mul_last = (bitcnt_q == sedh_pkg::BIT_W'(sedh_pkg::HASH_W - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q      <= first_start_i;
      b_q      <= second_start_i;
      k_q      <= span_length_i;
      status_q <= status_d;
      cmp_ok_q <= (op_i == sedh_pkg::OP_COMPARE) && !range_bad;
    end
    if (cmd_i.read) begin
      bitcnt_q <= '0;
    end else if (cmd_i.phase == sedh_pkg::PH_CRED) begin
      bitcnt_q <= crd_last ? '0 : bitcnt_q + sedh_pkg::BIT_W'(1);
    end else if (cmd_i.phase == sedh_pkg::PH_MUL) begin
      bitcnt_q <= mul_last ? '0 : bitcnt_q + sedh_pkg::BIT_W'(1);
    end
    if (cmd_i.phase == sedh_pkg::PH_ADD) begin
      k_q <= k_q - sedh_pkg::SPAN_W'(1);
    end
  end

  assign ch_idx   = 3'(sedh_pkg::CH_W - 1) - bitcnt_q[2:0];
  assign base_idx = sedh_pkg::BIT_W'(sedh_pkg::HASH_W - 1) - bitcnt_q;
  assign ch_bit_a = rd_a_q[ch_idx];
  assign ch_bit_b = rd_b_q[ch_idx];
  assign base_bit = base_q[base_idx];

  assign lane_cmd.phase = cmd_i.phase;
  assign lane_cmd.last  = crd_last;

  sedh_lane u_lane_first_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lane_cmd),
    .ch_bit_i   (ch_bit_a),
    .base_bit_i (base_bit),
    .modulus_i  (mod_one_q),
    .hash_o     (hash[0])
  );

  sedh_lane u_lane_second_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lane_cmd),
    .ch_bit_i   (ch_bit_b),
    .base_bit_i (base_bit),
    .modulus_i  (mod_one_q),
    .hash_o     (hash[1])
  );

  sedh_lane u_lane_first_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lane_cmd),
    .ch_bit_i   (ch_bit_a),
    .base_bit_i (base_bit),
    .modulus_i  (mod_two_q),
    .hash_o     (hash[2])
  );

  sedh_lane u_lane_second_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lane_cmd),
    .ch_bit_i   (ch_bit_b),
    .base_bit_i (base_bit),
    .modulus_i  (mod_two_q),
    .hash_o     (hash[3])
  );

  assign equal = cmp_ok_q && (hash[0] == hash[1]) && (hash[2] == hash[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_equal_q  <= equal;
      for (int i = 0; i < sedh_pkg::LANES; i++) begin
        out_hash_q[i] <= hash[i];
      end
    end
  end

  assign stat_o.go_cmp   = (op_i == sedh_pkg::OP_COMPARE) && !range_bad
                        && (span_length_i != '0);
  assign stat_o.crd_last = crd_last;
  assign stat_o.mul_last = mul_last;
  assign stat_o.k_one    = (k_q == sedh_pkg::SPAN_W'(1));
  assign stat_o.out_free = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_user_o  = out_status_q;
  assign m_data_o  = {3'b000, out_hash_q[3], out_hash_q[2], out_hash_q[1], out_hash_q[0],
                      out_equal_q};

  `SEDH_ASSERT(a_dp_length_bound, length_q <= sedh_pkg::LEN_W'(sedh_pkg::MAX_TEXT))
  `SEDH_ASSERT(a_dp_equal_only_ok, (out_valid_q && out_status_q != sedh_pkg::STATUS_OK) |-> !out_equal_q)
  `SEDH_ASSERT(a_dp_full_holds, (cmd_i.accept && op_i == sedh_pkg::OP_APPEND && full) |=> $stable(length_q))

endmodule
`default_nettype wire

>>> hdl/substring_equality_double_hash.sv
// Append, clear, unused and out-of-range or zero-span compare items go from acceptance to the emit
// state, which waits for a free output, then into the result register; a compare of span L reads
// each character, then does bit-serial modular reduction, multiply and add in the four hash lanes.
// One item is in work at a time; the next is accepted once the result is loaded for delivery.
// Reset is asynchronous and active low: it empties the string, restores the register defaults and
// clears the controller and result valid; the text store itself is not cleared.
`default_nettype none
module substring_equality_double_hash (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // character [7:0], first_start [17:8], second_start [27:18], span_length [38:28]
  input  wire logic [sedh_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // operation [1:0]
  input  wire logic [sedh_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // equal [0], first_hash_one [31:1], second_hash_one [62:32],
  // first_hash_two [93:63], second_hash_two [124:94]
  output logic [sedh_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // status [1:0]
  output logic [sedh_pkg::STAT_W-1:0]               m_axis_tuser,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sedh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [sedh_pkg::HASH_W-1:0]          cfg_data_i
);

  sedh_pkg::ctrl_cmd_t  cmd;
  sedh_pkg::ctrl_stat_t stat;
  sedh_pkg::op_e        op;

  assign op = sedh_pkg::op_e'(s_axis_tuser);

  sedh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sedh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op),
    .ch_i           (s_axis_tdata[7:0]),
    .first_start_i  (s_axis_tdata[17:8]),
    .second_start_i (s_axis_tdata[27:18]),
    .span_length_i  (s_axis_tdata[38:28]),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_data_o       (m_axis_tdata),
    .m_user_o       (m_axis_tuser)
  );

endmodule
`default_nettype wire
